### rtl/acpu_pkg.sv
// ----------------------------------------------------------------------------
// acpu_pkg
// Shared types and codes of the accumulator CPU execute core.
// ----------------------------------------------------------------------------
package acpu_pkg;

    // Instruction opcodes, bits 7..4 of the instruction byte
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_XOR  = 4'd2,
        OP_AND  = 4'd3,
        OP_OR   = 4'd4,
        OP_MOV  = 4'd5,
        OP_SHR  = 4'd6,
        OP_CMP  = 4'd7,
        OP_ADDC = 4'd8,
        OP_SHRC = 4'd9,
        OP_CMPC = 4'd10,
        OP_JMP  = 4'd11,
        OP_LD   = 4'd12,
        OP_ST   = 4'd13,
        OP_IMML = 4'd14,
        OP_IMMH = 4'd15
    } t_opcode;

    // Jump group selector, register field of a jump instruction
    typedef enum logic [2:0] {
        JC_JMP  = 3'd0,
        JC_CALL = 3'd1,
        JC_B    = 3'd2,
        JC_BEQ  = 3'd3,
        JC_BGT  = 3'd4,
        JC_BGE  = 3'd5,
        JC_BGTS = 3'd6,
        JC_BGES = 3'd7
    } t_jcond;

    // Memory request kinds
    typedef enum logic [1:0] {
        REQ_FETCH = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } t_req_kind;

    // Special registers
    localparam logic [2:0] REG_CS = 3'd0;
    localparam logic [2:0] REG_DS = 3'd1;
    localparam logic [2:0] REG_RA = 3'd7;

    localparam int unsigned TDATA_OUT_W = 40;

    // One result item
    typedef struct packed {
        t_req_kind   kind;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic [7:0]  acc;
        logic        zf;
        logic        cf;
        logic        vf;
        logic        last;
    } t_result;

    // Status of the execute stage toward the pipeline control
    typedef struct packed {
        logic emit;     // a result is presented this cycle
        logic consume;  // the held item is finished this cycle
    } t_exec_stat;

endpackage

### rtl/acpu_alu.sv
// ----------------------------------------------------------------------------
// acpu_alu
// 8-bit ALU: add/sub with carry, logic ops, shifts, and flag generation.
// ----------------------------------------------------------------------------
module acpu_alu (
    input  acpu_pkg::t_opcode i_op,
    input  logic [7:0]        i_a,
    input  logic [7:0]        i_b,
    input  logic              i_cf,
    output logic [7:0]        o_res,
    output logic              o_zf,
    output logic              o_cf,
    output logic              o_vf
);
    import acpu_pkg::*;

    logic [7:0] w_b_eff;
    logic       w_cin;
    logic [8:0] w_sum;
    logic [8:0] w_res;
    logic       w_shift;

    always_comb begin
        w_b_eff = i_b;
        w_cin   = 1'b0;
        case (i_op) inside
            OP_SUB, OP_CMP: begin
                w_b_eff = ~i_b;
                w_cin   = 1'b1;
            end
            OP_CMPC: begin
                w_b_eff = ~i_b;
                w_cin   = i_cf;
            end
            OP_ADDC: w_cin = i_cf;
            default: ;
        endcase
    end

    assign w_sum = {1'b0, i_a} + {1'b0, w_b_eff} + {8'd0, w_cin};

    always_comb begin
        w_shift = 1'b0;
        case (i_op) inside
            OP_XOR:  w_res = {1'b0, i_a ^ i_b};
            OP_AND:  w_res = {1'b0, i_a & i_b};
            OP_OR:   w_res = {1'b0, i_a | i_b};
            OP_SHR: begin
                w_res   = {2'b00, i_a[7:1]};
                w_shift = 1'b1;
            end
            OP_SHRC: begin
                w_res   = {1'b0, i_cf, i_a[7:1]};
                w_shift = 1'b1;
            end
            default: w_res = w_sum;
        endcase
    end

    assign o_res = w_res[7:0];
    assign o_zf  = (w_res[7:0] == 8'd0);
    // shifts return the bit shifted out
    assign o_cf  = w_shift ? i_a[0] : w_res[8];
    assign o_vf  = (i_a[6] & w_b_eff[6] & w_res[7]) |
                   (i_a[7] & w_b_eff[7] & ~w_res[7]);

endmodule

### rtl/acpu_exec.sv
// ----------------------------------------------------------------------------
// acpu_exec
// Architectural state and execution of one memory response.
// ----------------------------------------------------------------------------
module acpu_exec (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,   // an item sits in the input register
    input  logic                 i_fire,    // the result register takes a result
    input  logic                 i_action,
    input  logic [7:0]           i_data,
    output acpu_pkg::t_result    o_result,
    output acpu_pkg::t_exec_stat o_stat
);
    import acpu_pkg::*;

    logic [7:0]  r_gpr [8];
    logic [7:0]  r_acc;
    logic [15:0] r_ip;
    logic        r_zf;
    logic        r_cf;
    logic        r_vf;
    logic        r_pending;
    logic [2:0]  r_target;
    logic        r_st_phase;   // store: write already issued, fetch next

    logic [7:0]  n_gpr [8];
    logic [7:0]  n_acc;
    logic [15:0] n_ip;
    logic        n_zf;
    logic        n_cf;
    logic        n_vf;
    logic        n_pending;
    logic [2:0]  n_target;
    logic        n_st_phase;

    t_opcode     w_op;
    logic        w_d;
    logic [2:0]  w_r;
    logic [7:0]  w_a;
    logic [7:0]  w_b;
    logic [7:0]  w_alu_res;
    logic        w_alu_zf;
    logic        w_alu_cf;
    logic        w_alu_vf;
    logic [15:0] w_ip_inc;
    logic [15:0] w_page_addr;
    logic [7:0]  w_jmp_low;
    logic [15:0] w_jmp_off;
    logic        w_take;
    logic        w_consume;
    t_req_kind   w_kind;
    logic [15:0] w_addr;
    logic [7:0]  w_wdata;
    logic        w_last;

    assign w_op        = t_opcode'(i_data[7:4]);
    assign w_d         = i_data[3];
    assign w_r         = i_data[2:0];
    assign w_a         = w_d ? r_gpr[w_r] : r_acc;
    assign w_b         = w_d ? r_acc : r_gpr[w_r];
    assign w_ip_inc    = r_ip + 16'd1;
    assign w_page_addr = w_d ? {r_gpr[REG_DS], r_acc} : {8'h00, r_acc};
    assign w_jmp_low   = w_d ? (r_acc | 8'hF0) : r_acc;
    assign w_jmp_off   = w_d ? {8'hFF, r_acc | 8'hF0} : {8'h00, r_acc};

    acpu_alu u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .i_cf  (r_cf),
        .o_res (w_alu_res),
        .o_zf  (w_alu_zf),
        .o_cf  (w_alu_cf),
        .o_vf  (w_alu_vf)
    );

    always_comb begin
        unique case (t_jcond'(w_r))
            JC_JMP:  w_take = 1'b0;
            JC_CALL: w_take = 1'b0;
            JC_B:    w_take = 1'b1;
            JC_BEQ:  w_take = r_zf;
            JC_BGT:  w_take = r_cf & ~r_zf;
            JC_BGE:  w_take = r_cf;
            JC_BGTS: w_take = r_vf & ~r_zf;
            JC_BGES: w_take = r_vf;
        endcase
    end

    always_comb begin
        n_gpr      = r_gpr;
        n_acc      = r_acc;
        n_ip       = r_ip;
        n_zf       = r_zf;
        n_cf       = r_cf;
        n_vf       = r_vf;
        n_pending  = r_pending;
        n_target   = r_target;
        n_st_phase = r_st_phase;
        w_consume  = 1'b1;
        w_kind     = REQ_FETCH;
        w_addr     = r_ip;
        w_wdata    = 8'd0;
        w_last     = 1'b1;

        if (i_action) begin
            // load data; stray data just refetches at ip
            if (r_pending) begin
                n_gpr[r_target] = i_data;
                n_pending       = 1'b0;
            end
        end else begin
            n_pending = 1'b0;
            n_ip      = w_ip_inc;
            w_addr    = w_ip_inc;
            unique case (w_op) inside
                OP_ADD, OP_SUB, OP_XOR, OP_AND, OP_OR, OP_SHR,
                OP_CMP, OP_ADDC, OP_SHRC, OP_CMPC: begin
                    if (w_op != OP_CMP) begin
                        if (w_d) n_acc = w_alu_res;
                        else     n_gpr[w_r] = w_alu_res;
                    end
                    n_zf = w_alu_zf;
                    n_cf = w_alu_cf;
                    n_vf = w_alu_vf;
                end
                OP_MOV: begin
                    if (w_d) n_acc = w_a;
                    else     n_gpr[w_r] = w_a;
                end
                OP_JMP: begin
                    if (w_r == JC_JMP || w_r == JC_CALL) begin
                        if (w_r == JC_CALL) n_gpr[REG_RA] = w_ip_inc[7:0];
                        n_ip = {r_gpr[REG_CS], w_jmp_low};
                    end else if (w_take) begin
                        n_ip = r_ip + w_jmp_off;
                    end
                    w_addr = n_ip;
                end
                OP_LD: begin
                    n_pending = 1'b1;
                    n_target  = w_r;
                    w_kind    = REQ_READ;
                    w_addr    = w_page_addr;
                end
                OP_ST: begin
                    if (!r_st_phase) begin
                        // first pass: the write; item stays for the fetch
                        w_consume  = 1'b0;
                        n_st_phase = 1'b1;
                        w_kind     = REQ_WRITE;
                        w_addr     = w_page_addr;
                        w_wdata    = r_gpr[w_r];
                        w_last     = 1'b0;
                    end else begin
                        n_st_phase = 1'b0;
                    end
                end
                OP_IMML: n_acc = {4'h0, i_data[3:0]};
                OP_IMMH: n_acc = {i_data[3:0], 4'h0};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_gpr[i] <= 8'd0;
            r_acc      <= 8'd0;
            r_ip       <= 16'd0;
            r_zf       <= 1'b0;
            r_cf       <= 1'b0;
            r_vf       <= 1'b0;
            r_pending  <= 1'b0;
            r_target   <= 3'd0;
            r_st_phase <= 1'b0;
        end else if (i_valid && i_fire) begin
            r_st_phase <= n_st_phase;
            if (w_consume) begin
                r_gpr     <= n_gpr;
                r_acc     <= n_acc;
                r_ip      <= n_ip;
                r_zf      <= n_zf;
                r_cf      <= n_cf;
                r_vf      <= n_vf;
                r_pending <= n_pending;
                r_target  <= n_target;
            end
        end
    end

    // results carry the state as it stands after the whole item
    assign o_result.kind  = w_kind;
    assign o_result.addr  = w_addr;
    assign o_result.wdata = w_wdata;
    assign o_result.acc   = n_acc;
    assign o_result.zf    = n_zf;
    assign o_result.cf    = n_cf;
    assign o_result.vf    = n_vf;
    assign o_result.last  = w_last;

    assign o_stat.emit    = i_valid;
    assign o_stat.consume = i_valid & i_fire & w_consume;

endmodule

### rtl/accumulator_cpu_execute_core.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_core
// Execute core of an 8-bit accumulator CPU, streaming in and out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*): one memory response per transfer. tuser says what
//   it is (0 = instruction byte, 1 = data of the pending load), tdata holds
//   the byte.
//   Master channel (o_m_*): memory requests. tuser is the request kind
//   (fetch, read, write), tdata the address, store byte and the accumulator
//   and flags after the instruction; tlast marks the final request of a
//   response.
//   Path: a response enters the input register on its transfer, and its first
//   request is loaded into the result register when that register can load.
//   Throughput: one response per cycle while tready is high. A store gives
//   two requests (write, then fetch) and holds the execute stage for both.
//   Stall: when the receiver holds tready low, the result register keeps its
//   request, the execute stage waits and the input register stays full; the
//   slave side keeps taking a transfer whenever the input register is empty
//   or drains in the same cycle.
//   Reset: registers, accumulator, pointer and flags clear; the first fetch
//   at address 0 is implied and no request is issued by reset.
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,  // [7:0] data
    input  logic [0:0]                          i_s_tuser,  // [0] action
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [15:0] req_address, [23:16] write_data, [31:24] accumulator,
    // [32] zero_flag, [33] carry_flag, [34] overflow_flag, [39:35] zero
    output logic [acpu_pkg::TDATA_OUT_W-1:0]    o_m_tdata,
    output logic [1:0]                          o_m_tuser,  // [1:0] req_kind
    output logic                                o_m_tlast
);
    import acpu_pkg::*;

    // input register
    logic       r_in_valid;
    logic       r_in_action;
    logic [7:0] r_in_data;

    // result register
    logic       r_out_valid;
    t_result    r_out;

    t_result    w_result;
    t_exec_stat w_stat;
    logic       w_out_take;   // result register can load this cycle
    logic       w_s_xfer;

    assign w_out_take = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_stat.consume;
    assign w_s_xfer   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_stat.consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_in_action <= i_s_tuser[0];
            r_in_data   <= i_s_tdata;
        end
    end

    acpu_exec u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_fire   (w_out_take),
        .i_action (r_in_action),
        .i_data   (r_in_data),
        .o_result (w_result),
        .o_stat   (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_take) begin
            r_out_valid <= w_stat.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take && w_stat.emit) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out.vf, r_out.cf, r_out.zf, r_out.acc,
                         r_out.wdata, r_out.addr};
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;

endmodule

### rtl/acpu_checker.sv
// ----------------------------------------------------------------------------
// acpu_checker
// Port-level checks of the execute core, bound to the top level.
// ----------------------------------------------------------------------------
module acpu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [acpu_pkg::TDATA_OUT_W-1:0] o_m_tdata,
    input logic [1:0]                       o_m_tuser,
    input logic                             o_m_tlast
);
    import acpu_pkg::*;

    // a stalled request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled request changed");

    // a store write is never the final request of its response
    a_write_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == REQ_WRITE |-> !o_m_tlast)
        else $error("write request marked last");

    // the fetch of a store follows its write in the very next cycle
    a_write_then_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser == REQ_WRITE |=>
        o_m_tvalid && o_m_tuser == REQ_FETCH && o_m_tlast)
        else $error("store write not followed by fetch");

    // store byte is zero outside writes, and the pad bits stay zero
    a_wdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != REQ_WRITE |->
        o_m_tdata[23:16] == 8'd0 && o_m_tdata[39:35] == 5'd0)
        else $error("nonzero store byte on a non-write request");

endmodule

bind accumulator_cpu_execute_core acpu_checker u_acpu_checker (.*);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accumulator CPU execute core.
// Memory responses (instruction bytes and load data) go in on the slave
// stream with random gaps. The request stream is checked against an
// untimed model of the core while the master side stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import acpu_pkg::*;

    // What a slave-side transfer carries (tuser)
    localparam logic ACT_INSTR = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT   = 2000;  // cycles without any transfer
    localparam int DRAIN_CYCLES = 10;

    // ------------------------------------------------------------------------
    // Untimed model of the core plus the queue of requests it owes us.
    // ------------------------------------------------------------------------
    class acpu_tracker;
        logic [7:0]  regs [8];
        logic [7:0]  acc;
        logic [15:0] ip;
        logic        zf, cf, vf;
        logic        load_pending;
        logic [2:0]  load_target;
        t_result     owed_reqs [$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = 8'h00;
            acc          = 8'h00;
            ip           = 16'h0000;
            zf           = 1'b0;
            cf           = 1'b0;
            vf           = 1'b0;
            load_pending = 1'b0;
            load_target  = 3'd0;
            errors       = 0;
        endfunction

        // b arrives already inverted for the subtracting ops
        function void set_flags(logic [7:0] a, logic [7:0] b, logic [8:0] res);
            zf = (res[7:0] == 8'h00);
            cf = res[8];
            vf = (a[6] & b[6] & res[7]) | (a[7] & b[7] & ~res[7]);
        endfunction

        // Status fields always carry the state after the instruction
        function void owe(t_req_kind kind, logic [15:0] addr, logic [7:0] wdata,
                          logic last);
            t_result req;
            req.kind  = kind;
            req.addr  = addr;
            req.wdata = wdata;
            req.acc   = acc;
            req.zf    = zf;
            req.cf    = cf;
            req.vf    = vf;
            req.last  = last;
            owed_reqs.push_back(req);
        endfunction

        // One accepted memory response: run it and queue the requests it causes
        function void note_response(logic act, logic [7:0] byte_v);
            t_opcode     op;
            logic        d;
            logic [2:0]  r;
            logic [7:0]  a, b, low;
            logic [8:0]  res;
            logic [15:0] page, off;
            logic        take, do_flags, do_write, shift_cf;

            if (act == ACT_LOAD) begin
                // stray data is dropped, the fetch is reissued either way
                if (load_pending) begin
                    regs[load_target] = byte_v;
                    load_pending      = 1'b0;
                end
                owe(REQ_FETCH, ip, 8'h00, 1'b1);
                return;
            end

            load_pending = 1'b0;  // an instruction cancels a pending load
            op   = t_opcode'(byte_v[7:4]);
            d    = byte_v[3];
            r    = byte_v[2:0];
            a    = d ? regs[r] : acc;
            b    = d ? acc : regs[r];
            page = d ? {regs[REG_DS], acc} : {8'h00, acc};

            res      = '0;
            do_flags = 1'b1;
            do_write = 1'b1;
            shift_cf = 1'b0;

            case (op)
                OP_ADD:  res = a + b;
                OP_SUB: begin
                    b   = ~b;
                    res = a + b + 9'd1;
                end
                OP_XOR:  res = {1'b0, a ^ b};
                OP_AND:  res = {1'b0, a & b};
                OP_OR:   res = {1'b0, a | b};
                OP_MOV: begin
                    res      = {1'b0, a};
                    do_flags = 1'b0;
                end
                OP_SHR: begin
                    res      = {2'b00, a[7:1]};
                    shift_cf = 1'b1;
                end
                OP_CMP: begin
                    b        = ~b;
                    res      = a + b + 9'd1;
                    do_write = 1'b0;
                end
                OP_ADDC: res = a + b + cf;
                OP_SHRC: begin
                    res      = {1'b0, cf, a[7:1]};
                    shift_cf = 1'b1;
                end
                OP_CMPC: begin
                    // carry-in compare that still writes back
                    b   = ~b;
                    res = a + b + cf;
                end
                OP_JMP: begin
                    low = d ? (acc | 8'hf0) : acc;
                    off = d ? {8'hff, acc | 8'hf0} : {8'h00, acc};
                    case (t_jcond'(r))
                        JC_BEQ:  take = zf;
                        JC_BGT:  take = cf & ~zf;
                        JC_BGE:  take = cf;
                        JC_BGTS: take = vf & ~zf;
                        JC_BGES: take = vf;
                        JC_B:    take = 1'b1;
                        default: take = 1'b0;
                    endcase
                    if (r == JC_JMP || r == JC_CALL) begin
                        if (r == JC_CALL)
                            regs[REG_RA] = ip[7:0] + 8'd1;
                        ip = {regs[REG_CS], low};
                    end else if (take) begin
                        ip = ip + off;
                    end else begin
                        ip = ip + 16'd1;
                    end
                    owe(REQ_FETCH, ip, 8'h00, 1'b1);
                    return;
                end
                OP_LD: begin
                    load_pending = 1'b1;
                    load_target  = r;
                    ip           = ip + 16'd1;
                    owe(REQ_READ, page, 8'h00, 1'b1);
                    return;
                end
                OP_ST: begin
                    owe(REQ_WRITE, page, regs[r], 1'b0);
                    do_flags = 1'b0;
                    do_write = 1'b0;
                end
                OP_IMML: begin
                    acc      = {4'h0, byte_v[3:0]};
                    do_flags = 1'b0;
                    do_write = 1'b0;
                end
                OP_IMMH: begin
                    acc      = {byte_v[3:0], 4'h0};
                    do_flags = 1'b0;
                    do_write = 1'b0;
                end
            endcase

            if (do_write) begin
                if (d)
                    acc = res[7:0];
                else
                    regs[r] = res[7:0];
            end
            if (do_flags)
                set_flags(a, b, res);
            if (shift_cf)
                cf = a[0];

            ip = ip + 16'd1;
            owe(REQ_FETCH, ip, 8'h00, 1'b1);
        endfunction

        function void compare_field(string name, int unsigned want_v,
                                    int unsigned got_v);
            if (want_v != got_v) begin
                $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
                errors++;
            end
        endfunction

        // One accepted request, straight off the master bus
        function void check_request(logic [1:0] kind_bits,
                                    logic [TDATA_OUT_W-1:0] bus, logic last);
            t_result want;
            if (owed_reqs.size() == 0) begin
                $error("unexpected request: kind %0d addr %h", kind_bits, bus[15:0]);
                errors++;
                return;
            end
            want = owed_reqs.pop_front();
            compare_field("req_kind",      want.kind,  kind_bits);
            compare_field("req_address",   want.addr,  bus[15:0]);
            compare_field("write_data",    want.wdata, bus[23:16]);
            compare_field("accumulator",   want.acc,   bus[31:24]);
            compare_field("zero_flag",     want.zf,    bus[32]);
            compare_field("carry_flag",    want.cf,    bus[33]);
            compare_field("overflow_flag", want.vf,    bus[34]);
            compare_field("last",          want.last,  last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and bus signals. Every input is known from time zero.
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n   = 1'b0;
    logic                   s_valid = 1'b0;
    logic [7:0]             s_data  = 8'h00;   // [7:0] data
    logic [0:0]             s_user  = 1'b0;    // [0] action
    logic                   m_ready = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [TDATA_OUT_W-1:0] m_data;            // address, store byte, acc, flags
    logic [1:0]             m_user;            // [1:0] req_kind
    logic                   m_last;

    acpu_tracker tracker;
    bit          quiet;             // no idling on either side while set
    bit          load_outstanding;  // last transfer was an LD instruction
    int          idle_cycles;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    accumulator_cpu_execute_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user),
        .o_m_tlast  (m_last)
    );

    // Mostly back-to-back, sometimes a few cycles, rarely a long hole
    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    function automatic logic [7:0] enc(t_opcode op, logic d, logic [2:0] r);
        return {op, d, r};
    endfunction

    function automatic logic [7:0] imm_byte(t_opcode op, logic [3:0] v);
        return {op, v};
    endfunction

    // Called right after a rising edge; returns at the edge of the transfer.
    // tready is read before the core's registers update in this time step.
    task automatic send_response(logic act, logic [7:0] byte_v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= act;
        s_data  <= byte_v;
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        tracker.note_response(act, byte_v);
        load_outstanding = (act == ACT_INSTR) && (byte_v[7:4] == OP_LD);
    endtask

    // Receiver: ready runs of random length broken by random stalls
    initial begin
        int run, gap;
        forever begin
            m_ready <= 1'b1;
            run = $urandom_range(1, 24);
            repeat (run) @(posedge clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Every accepted request is checked against the oldest one owed
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready)
            tracker.check_request(m_user, m_data, m_last);
    end

    // Watchdog: a stuck handshake on either side ends the run
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int roll;
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: all-zero and all-one bytes, every ALU op in at least
        // one direction, DS-page store, load completed, load cancelled by an
        // instruction, stray load data, and the whole jump group.
        send_response(ACT_INSTR, enc(OP_ADD, 1'b0, REG_CS));  // zero result
        send_response(ACT_INSTR, imm_byte(OP_IMMH, 4'hf));    // acc = 0xf0
        send_response(ACT_INSTR, enc(OP_MOV, 1'b0, 3'd2));
        send_response(ACT_INSTR, enc(OP_ADD, 1'b1, 3'd2));    // carry out
        send_response(ACT_INSTR, enc(OP_ADDC, 1'b0, 3'd2));
        send_response(ACT_INSTR, enc(OP_SUB, 1'b0, 3'd3));
        send_response(ACT_INSTR, enc(OP_CMP, 1'b1, 3'd2));
        send_response(ACT_INSTR, enc(OP_CMPC, 1'b0, 3'd3));
        send_response(ACT_INSTR, enc(OP_XOR, 1'b1, 3'd2));
        send_response(ACT_INSTR, enc(OP_AND, 1'b0, 3'd2));
        send_response(ACT_INSTR, enc(OP_OR, 1'b1, 3'd3));
        send_response(ACT_INSTR, enc(OP_SHR, 1'b1, 3'd2));
        send_response(ACT_INSTR, enc(OP_SHRC, 1'b0, 3'd3));
        send_response(ACT_INSTR, imm_byte(OP_IMML, 4'h3));
        send_response(ACT_INSTR, enc(OP_MOV, 1'b0, REG_DS));  // DS page = 0x03
        send_response(ACT_INSTR, enc(OP_ST, 1'b1, 3'd2));
        send_response(ACT_INSTR, enc(OP_LD, 1'b0, 3'd4));
        send_response(ACT_LOAD, 8'ha5);
        send_response(ACT_INSTR, enc(OP_LD, 1'b1, 3'd5));
        send_response(ACT_INSTR, imm_byte(OP_IMML, 4'h8));    // drops the load
        send_response(ACT_LOAD, 8'hff);                       // stray data
        send_response(ACT_INSTR, enc(OP_JMP, 1'b0, JC_JMP));
        send_response(ACT_INSTR, enc(OP_JMP, 1'b1, JC_CALL));
        send_response(ACT_INSTR, enc(OP_JMP, 1'b1, JC_B));    // backward branch
        for (int c = JC_BEQ; c <= JC_BGES; c++)
            send_response(ACT_INSTR, enc(OP_JMP, c[0], 3'(c)));

        // Random part: loads are mostly answered with their data, a few
        // data transfers arrive with nothing pending.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 300 && i < 450);
            if (i == 700) begin
                // hold off until every owed request has been seen
                s_valid <= 1'b0;
                do
                    @(posedge clk);
                while (tracker.owed_reqs.size() != 0);
            end
            roll = $urandom_range(0, 99);
            if (load_outstanding && roll < 85)
                send_response(ACT_LOAD, 8'($urandom_range(0, 255)));
            else if (roll < 4)
                send_response(ACT_LOAD, 8'($urandom_range(0, 255)));
            else
                send_response(ACT_INSTR, 8'($urandom_range(0, 255)));
        end
        quiet = 1'b0;

        s_valid <= 1'b0;
        while (tracker.owed_reqs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
rtl/acpu_pkg.sv
rtl/acpu_alu.sv
rtl/acpu_exec.sv
rtl/accumulator_cpu_execute_core.sv
rtl/acpu_checker.sv
tb/tb.sv
